>>> design/scene_graph_affine_composer_unit_macros.svh
// ----------------------------------------------------------------------------
// scene graph affine composer assertion macros
// shared concurrent assertion forms used by the top level
// ----------------------------------------------------------------------------
`ifndef SCENE_GRAPH_AFFINE_COMPOSER_UNIT_MACROS_SVH
`define SCENE_GRAPH_AFFINE_COMPOSER_UNIT_MACROS_SVH

// consequent must hold in the same cycle
`define SGAC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// consequent must hold in the next cycle
`define SGAC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/sgac_pkg.sv
// ----------------------------------------------------------------------------
// sgac_pkg
// shared types, constants and arithmetic helpers of the affine composer
// ----------------------------------------------------------------------------
package sgac_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_ENTRIES = 24;
	localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
	localparam int ITER_W = $clog2(ATAN_ENTRIES);

	localparam logic signed [17:0] ANG_FULL  = 18'sd46080;
	localparam logic signed [17:0] ANG_HALF  = 18'sd23040;
	localparam logic signed [17:0] ANG_QUART = 18'sd11520;

	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	// reciprocal of 25 for the percent to q16 conversion
	localparam logic signed [31:0] DIV25_MUL = 32'sd1374389535;
	localparam int DIV25_SHIFT = 35;

	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic signed [31:0] la;
		logic signed [31:0] lb;
		logic signed [31:0] lc;
		logic signed [31:0] ld;
		logic signed [36:0] ltx;
		logic signed [36:0] lty;
		logic               start;
		logic               last;
	} sgac_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} sgac_qstat_t;

	function automatic logic signed [31:0] atan_lut(input logic [ITER_W-1:0] i);
		logic signed [31:0] r;
		case (i)
			5'd0:    r = 32'sd377487360;
			5'd1:    r = 32'sd222843801;
			5'd2:    r = 32'sd117744544;
			5'd3:    r = 32'sd59768969;
			5'd4:    r = 32'sd30000467;
			5'd5:    r = 32'sd15014858;
			5'd6:    r = 32'sd7509261;
			5'd7:    r = 32'sd3754860;
			5'd8:    r = 32'sd1877459;
			5'd9:    r = 32'sd938733;
			5'd10:   r = 32'sd469367;
			5'd11:   r = 32'sd234683;
			5'd12:   r = 32'sd117342;
			5'd13:   r = 32'sd58671;
			5'd14:   r = 32'sd29335;
			5'd15:   r = 32'sd14668;
			5'd16:   r = 32'sd7334;
			5'd17:   r = 32'sd3667;
			5'd18:   r = 32'sd1833;
			5'd19:   r = 32'sd917;
			5'd20:   r = 32'sd458;
			5'd21:   r = 32'sd229;
			5'd22:   r = 32'sd115;
			5'd23:   r = 32'sd57;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat_to_32(input logic signed [53:0] v);
		logic signed [31:0] r;
		if (v > 54'sd2147483647) r = 32'sh7fffffff;
		else if (v < -54'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [47:0] sat_to_48(input logic signed [53:0] v);
		logic signed [47:0] r;
		if (v > 54'sd140737488355327) r = 48'sh7fffffffffff;
		else if (v < -54'sd140737488355328) r = 48'sh800000000000;
		else r = v[47:0];
		return r;
	endfunction

endpackage

>>> design/sgac_front.sv
// ----------------------------------------------------------------------------
// sgac_front
// accepts a node, builds its local rotate-scale matrix and translation
// ----------------------------------------------------------------------------
module sgac_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [31:0]   pos_x,
	input  logic signed [31:0]   pos_y,
	input  logic signed [16:0]   rotation,
	input  logic signed [23:0]   scale_x,
	input  logic signed [23:0]   scale_y,
	input  logic                 chain_start,
	input  logic                 chain_end,
	input  sgac_pkg::sgac_qstat_t qstat,
	output logic                 push,
	output sgac_pkg::sgac_entry_t entry
);
	import sgac_pkg::*;

	typedef enum logic [3:0] {
		F_IDLE, F_DIVX, F_DIVY, F_CORD, F_MLA, F_MLB, F_MLC, F_MLD, F_LD, F_PUSH
	} fstate_t;

	fstate_t state_q;

	logic signed [17:0] rot_q;
	logic signed [23:0] sx_in_q, sy_in_q;
	logic signed [26:0] sx_q, sy_q;
	logic signed [33:0] cx_q, cy_q;
	logic signed [31:0] cz_q;
	logic               flip_q;
	logic [ITER_W-1:0]  iter_q;
	logic signed [31:0] la_q, lb_q, lc_q, ld_q;
	logic signed [36:0] ltx_q, lty_q;
	logic               start_q, last_q;

	logic signed [34:0] op_a;
	logic signed [31:0] op_b;
	logic signed [66:0] prod_q;

	logic signed [17:0] m_red, m_fold;
	logic               fold;
	logic signed [33:0] nx, ny;
	logic signed [31:0] nz;
	logic signed [26:0] q_scale;
	logic signed [31:0] rnd_val;

	function automatic logic [29:0] pct_num(input logic signed [23:0] s);
		logic [23:0] mag;
		mag = s[23] ? 24'(-s) : 24'(s);
		return {mag, 6'd0} + 30'd12;
	endfunction

	// angle reduction into [-180,180) then fold into [-90,90]
	always_comb begin
		if (rot_q >= ANG_HALF) m_red = rot_q - ANG_FULL;
		else if (rot_q < -ANG_HALF) m_red = rot_q + ANG_FULL;
		else m_red = rot_q;
		fold = 1'b0;
		m_fold = m_red;
		if (m_red > ANG_QUART) begin
			m_fold = m_red - ANG_HALF;
			fold = 1'b1;
		end else if (m_red < -ANG_QUART) begin
			m_fold = m_red + ANG_HALF;
			fold = 1'b1;
		end
	end

	// one cordic rotation step
	always_comb begin
		if (!cz_q[31]) begin
			nx = cx_q - (cy_q >>> iter_q);
			ny = cy_q + (cx_q >>> iter_q);
			nz = cz_q - atan_lut(iter_q);
		end else begin
			nx = cx_q + (cy_q >>> iter_q);
			ny = cy_q - (cx_q >>> iter_q);
			nz = cz_q + atan_lut(iter_q);
		end
	end

	// shared multiplier operand select
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (state_q)
			F_DIVX: begin
				op_a = 35'(pct_num(sx_in_q));
				op_b = DIV25_MUL;
			end
			F_DIVY: begin
				op_a = 35'(pct_num(sy_in_q));
				op_b = DIV25_MUL;
			end
			F_MLA: begin
				op_a = 35'(cx_q);
				op_b = 32'(sx_q);
			end
			F_MLB: begin
				op_a = 35'(cy_q);
				op_b = 32'(sx_q);
			end
			F_MLC: begin
				op_a = -35'(cy_q);
				op_b = 32'(sy_q);
			end
			F_MLD: begin
				op_a = 35'(cx_q);
				op_b = 32'(sy_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// quotient by 25 with sign of the scale that is in flight
	always_comb begin
		logic [26:0] qmag;
		logic        neg;
		qmag = 27'(prod_q >>> DIV25_SHIFT);
		neg = (state_q == F_DIVY) ? sx_in_q[23] : sy_in_q[23];
		q_scale = neg ? -$signed(qmag) : $signed(qmag);
	end

	always_comb begin
		logic signed [66:0] r;
		r = prod_q + 67'sd536870912;
		rnd_val = sat_to_32(54'($signed(r[66:30])));
	end

	always_ff @(posedge clk) begin
		prod_q <= op_a * op_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			iter_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						rot_q <= chain_start ? -18'(rotation) : 18'(rotation);
						sx_in_q <= scale_x;
						sy_in_q <= scale_y;
						ltx_q <= (37'(pos_x) <<< 4) + (37'(pos_x) <<< 2);
						lty_q <= (37'(pos_y) <<< 4) + (37'(pos_y) <<< 2);
						start_q <= chain_start;
						last_q <= chain_end;
						state_q <= F_DIVX;
					end
				end
				F_DIVX: begin
					cx_q <= CORDIC_GAIN_Q30;
					cy_q <= '0;
					cz_q <= {m_fold[15:0], 16'h0000};
					flip_q <= fold;
					iter_q <= '0;
					state_q <= F_DIVY;
				end
				F_DIVY: begin
					sx_q <= q_scale;
					state_q <= F_CORD;
				end
				F_CORD: begin
					if (iter_q == '0) sy_q <= q_scale;
					cz_q <= nz;
					if (iter_q == ITER_W'(CORDIC_ITERS - 1)) begin
						cx_q <= flip_q ? -nx : nx;
						cy_q <= flip_q ? -ny : ny;
						state_q <= F_MLA;
					end else begin
						cx_q <= nx;
						cy_q <= ny;
						iter_q <= iter_q + 1'b1;
					end
				end
				F_MLA: state_q <= F_MLB;
				F_MLB: begin
					la_q <= rnd_val;
					state_q <= F_MLC;
				end
				F_MLC: begin
					lb_q <= rnd_val;
					state_q <= F_MLD;
				end
				F_MLD: begin
					lc_q <= rnd_val;
					state_q <= F_LD;
				end
				F_LD: begin
					ld_q <= rnd_val;
					state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!qstat.full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	assign in_ready = (state_q == F_IDLE);
	assign push = (state_q == F_PUSH) && !qstat.full;
	assign entry = '{la: la_q, lb: lb_q, lc: lc_q, ld: ld_q, ltx: ltx_q, lty: lty_q,
		start: start_q, last: last_q};

endmodule

>>> design/sgac_queue.sv
// ----------------------------------------------------------------------------
// sgac_queue
// short fifo of local transforms between front and back
// ----------------------------------------------------------------------------
module sgac_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  sgac_pkg::sgac_entry_t wr_entry,
	input  logic                  pop,
	output sgac_pkg::sgac_entry_t rd_entry,
	output sgac_pkg::sgac_qstat_t qstat
);
	import sgac_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	sgac_entry_t      mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	assign rd_entry = mem_q[rd_ptr_q];
	assign qstat.full = (count_q == CNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);

endmodule

>>> design/sgac_back.sv
// ----------------------------------------------------------------------------
// sgac_back
// multiplies local transforms onto the accumulator and emits results
// ----------------------------------------------------------------------------
module sgac_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sgac_pkg::sgac_entry_t head,
	input  sgac_pkg::sgac_qstat_t qstat,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic signed [31:0]    mat_a,
	output logic signed [31:0]    mat_b,
	output logic signed [31:0]    mat_c,
	output logic signed [31:0]    mat_d,
	output logic signed [47:0]    trans_x,
	output logic signed [47:0]    trans_y
);
	import sgac_pkg::*;

	localparam int BACK_STEPS = 24;
	localparam int STEP_W = $clog2(BACK_STEPS);

	typedef enum logic [1:0] {B_IDLE, B_RUN, B_DRAIN, B_DONE} bstate_t;

	bstate_t           state_q;
	sgac_entry_t       e_q;
	logic [STEP_W-1:0] k_q;

	logic signed [31:0] acc_a_q, acc_b_q, acc_c_q, acc_d_q;
	logic signed [47:0] acc_tx_q, acc_ty_q;
	logic signed [31:0] nm_q [4];
	logic signed [47:0] nt_q [2];

	logic signed [53:0] prod_s1;
	logic               valid_s1, hi_s1, first_s1, last_s1;
	logic [2:0]         j_s1;
	logic signed [69:0] sum_q;

	logic signed [31:0] q_op;
	logic signed [36:0] t_op;
	logic signed [21:0] b_op;
	logic [2:0]         j;

	logic signed [31:0] r_a, r_b, r_c, r_d;
	logic signed [47:0] r_tx, r_ty;
	logic               stall;

	// step k: output j, term k[1], high or low half k[0]
	always_comb begin
		j = k_q[STEP_W-1:2];
		if (!k_q[1]) q_op = j[0] ? acc_b_q : acc_a_q;
		else q_op = j[0] ? acc_d_q : acc_c_q;
		case (j[2:1])
			2'd0:    t_op = k_q[1] ? 37'(e_q.lb) : 37'(e_q.la);
			2'd1:    t_op = k_q[1] ? 37'(e_q.ld) : 37'(e_q.lc);
			2'd2:    t_op = k_q[1] ? e_q.lty : e_q.ltx;
			default: t_op = '0;
		endcase
		b_op = k_q[0] ? 22'(t_op >>> 16) : $signed({6'd0, t_op[15:0]});
	end

	always_ff @(posedge clk) begin
		prod_s1 <= q_op * b_op;
		hi_s1 <= k_q[0];
		first_s1 <= (k_q[1:0] == 2'd0);
		last_s1 <= (k_q[1:0] == 2'd3);
		j_s1 <= j;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else valid_s1 <= (state_q == B_RUN);
	end

	// exact sum of products with rounding bias, then round and saturate
	always_ff @(posedge clk) begin
		logic signed [69:0] base, term, s;
		logic signed [53:0] sh;
		if (valid_s1) begin
			term = hi_s1 ? (70'(prod_s1) <<< 16) : 70'(prod_s1);
			if (!first_s1) base = sum_q;
			else if (j_s1 == 3'd4) base = (70'(acc_tx_q) <<< 16) + 70'sd32768;
			else if (j_s1 == 3'd5) base = (70'(acc_ty_q) <<< 16) + 70'sd32768;
			else base = 70'sd32768;
			s = base + term;
			sh = 54'(s >>> 16);
			sum_q <= s;
			if (last_s1) begin
				case (j_s1)
					3'd4:    nt_q[0] <= sat_to_48(sh);
					3'd5:    nt_q[1] <= sat_to_48(sh);
					default: nm_q[j_s1[1:0]] <= sat_to_32(sh);
				endcase
			end
		end
	end

	always_comb begin
		if (e_q.start) begin
			r_a = e_q.la;
			r_b = e_q.lb;
			r_c = e_q.lc;
			r_d = e_q.ld;
			r_tx = 48'(e_q.ltx);
			r_ty = 48'(e_q.lty);
		end else begin
			r_a = nm_q[0];
			r_b = nm_q[1];
			r_c = nm_q[2];
			r_d = nm_q[3];
			r_tx = nt_q[0];
			r_ty = nt_q[1];
		end
	end

	assign stall = e_q.last && out_valid && !out_ready;
	assign pop = (state_q == B_IDLE) && !qstat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			k_q <= '0;
			out_valid <= 1'b0;
			acc_a_q <= '0;
			acc_b_q <= '0;
			acc_c_q <= '0;
			acc_d_q <= '0;
			acc_tx_q <= '0;
			acc_ty_q <= '0;
		end else begin
			// a new result reloads the output register in the same cycle
			if (out_valid && out_ready && !(state_q == B_DONE && !stall && e_q.last))
				out_valid <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (!qstat.empty) begin
						e_q <= head;
						k_q <= '0;
						state_q <= head.start ? B_DONE : B_RUN;
					end
				end
				B_RUN: begin
					if (k_q == STEP_W'(BACK_STEPS - 1)) state_q <= B_DRAIN;
					else k_q <= k_q + 1'b1;
				end
				B_DRAIN: state_q <= B_DONE;
				B_DONE: begin
					if (!stall) begin
						acc_a_q <= r_a;
						acc_b_q <= r_b;
						acc_c_q <= r_c;
						acc_d_q <= r_d;
						acc_tx_q <= r_tx;
						acc_ty_q <= r_ty;
						if (e_q.last) begin
							out_valid <= 1'b1;
							mat_a <= r_a;
							mat_b <= r_b;
							mat_c <= r_c;
							mat_d <= r_d;
							trans_x <= r_tx;
							trans_y <= r_ty;
						end
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

>>> design/scene_graph_affine_composer_unit.sv
// ----------------------------------------------------------------------------
// scene_graph_affine_composer_unit
// composes the world affine transform of a display node from its ancestors
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | payload
//  s_*     | in  | s_tvalid/s_tready | tdata node fields, tuser chain start, tlast chain end
//  m_*     | out | m_tvalid/m_tready | tdata composed matrix and translation
//
//  front takes one request at a time, paced by the one-step-a-cycle cordic
//  and its shared scale multiplier, and waits in F_PUSH while the queue is full
//  back handles one entry at a time and skips the products for a chain start;
//  it has a single 32x22 multiplier stepping through 24 partial products
//  reset clears the accumulator to zero and empties the two-entry queue
//  a stalled result holds the back end; the front keeps working until the
//  queue fills, then holds s_tready low
// ----------------------------------------------------------------------------
`include "scene_graph_affine_composer_unit_macros.svh"

module scene_graph_affine_composer_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// pos_x[31:0], pos_y[63:32], rotation[80:64], scale_x[104:81],
	// scale_y[128:105], zero fill[135:129]
	input  logic [135:0] s_tdata,
	// chain_start
	input  logic         s_tuser,
	// chain_end
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// mat_a[31:0], mat_b[63:32], mat_c[95:64], mat_d[127:96],
	// trans_x[175:128], trans_y[223:176]
	output logic [223:0] m_tdata
);
	import sgac_pkg::*;

	sgac_entry_t f_entry, q_head;
	sgac_qstat_t qstat;
	logic        push, pop;

	logic signed [31:0] mat_a, mat_b, mat_c, mat_d;
	logic signed [47:0] trans_x, trans_y;

	// front: local transform per request
	sgac_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.pos_x      ($signed(s_tdata[31:0])),
		.pos_y      ($signed(s_tdata[63:32])),
		.rotation   ($signed(s_tdata[80:64])),
		.scale_x    ($signed(s_tdata[104:81])),
		.scale_y    ($signed(s_tdata[128:105])),
		.chain_start(s_tuser),
		.chain_end  (s_tlast),
		.qstat      (qstat),
		.push       (push),
		.entry      (f_entry)
	);

	// decouples the two halves
	sgac_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_entry(f_entry),
		.pop     (pop),
		.rd_entry(q_head),
		.qstat   (qstat)
	);

	// back: accumulate and emit
	sgac_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.qstat    (qstat),
		.pop      (pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.mat_a    (mat_a),
		.mat_b    (mat_b),
		.mat_c    (mat_c),
		.mat_d    (mat_d),
		.trans_x  (trans_x),
		.trans_y  (trans_y)
	);

	assign m_tdata = {trans_y, trans_x, mat_d, mat_c, mat_b, mat_a};

	// queue never overruns or underruns
	`SGAC_ASSERT_NOW(a_no_push_full, push, !qstat.full, "push into full queue")
	`SGAC_ASSERT_NOW(a_no_pop_empty, pop, !qstat.empty, "pop from empty queue")
	// front works on one request at a time
	`SGAC_ASSERT_NEXT(a_front_busy, s_tvalid && s_tready, !s_tready, "front took two requests")

endmodule

>>> test/scene_graph_affine_composer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scene_graph_affine_composer_unit_tb
// drives ancestor chains of display nodes into the composer, predicts each
// composed world transform in fixed point and checks every emitted matrix
// ----------------------------------------------------------------------------
module scene_graph_affine_composer_unit_tb;

	import sgac_pkg::*;

	typedef struct {
		longint a, b, c, d, tx, ty;
	} xform_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [135:0] s_tdata;
	logic         s_tuser;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [223:0] m_tdata;

	scene_graph_affine_composer_unit dut (.*);

	xform_t world_q[$];
	xform_t acc;
	int     error_count;
	int     idle_pct;
	int     stall_pct;
	longint arctan_q23[24];

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// random receiver stall
	always @(negedge clk) m_tready = ($urandom_range(99) >= stall_pct);

	function automatic longint clamp(longint v, int w);
		longint lim;
		lim = (longint'(1) <<< (w - 1)) - 1;
		if (v > lim) return lim;
		if (v < -lim - 1) return -lim - 1;
		return v;
	endfunction

	function automatic longint percent_q16(longint s);
		if (s >= 0) return (s * 64 + 12) / 25;
		return -((-s * 64 + 12) / 25);
	endfunction

	// cos and sin in q30 for a rotation in 1/128 degree
	task automatic sin_cos(input longint r, output longint co, output longint si);
		longint m, x, y, z, dx, dy;
		bit     flip;
		m = r % 46080;
		flip = 0;
		if (m < 0) m += 46080;
		if (m >= 23040) m -= 46080;
		if (m > 11520) begin
			m -= 23040;
			flip = 1;
		end else if (m < -11520) begin
			m += 23040;
			flip = 1;
		end
		x = 652032874;
		y = 0;
		z = m * 65536;
		for (int i = 0; i < CORDIC_ITERS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= arctan_q23[i];
			end else begin
				x += dx;
				y -= dy;
				z += arctan_q23[i];
			end
		end
		co = flip ? -x : x;
		si = flip ? -y : y;
	endtask

	function automatic longint trig_scale(longint t, longint s);
		return clamp((t * s + (longint'(1) <<< 29)) >>> 30, 32);
	endfunction

	// q1 times t1 plus q2 times t2 over 2^16 with rounding, split so no product overflows
	function automatic longint dot_q16(longint q1, longint t1, longint q2, longint t2);
		longint p1, p2, w;
		p1 = q1 * (t1 & 64'hffff);
		p2 = q2 * (t2 & 64'hffff);
		w = q1 * (t1 >>> 16) + (p1 >>> 16) + q2 * (t2 >>> 16) + (p2 >>> 16);
		return w + (((p1 & 64'hffff) + (p2 & 64'hffff) + 64'h8000) >>> 16);
	endfunction

	task automatic compose_node(input logic signed [31:0] px, input logic signed [31:0] py,
			input logic signed [16:0] rot, input logic signed [23:0] sx,
			input logic signed [23:0] sy, input logic start, input logic fin);
		longint r, co, si, sxq, syq, la, lb, lc, ld, ltx, lty;
		xform_t n;
		r = longint'(rot);
		if (start) r = -r;
		sin_cos(r, co, si);
		sxq = percent_q16(longint'(sx));
		syq = percent_q16(longint'(sy));
		la = trig_scale(co, sxq);
		lb = trig_scale(si, sxq);
		lc = trig_scale(-si, syq);
		ld = trig_scale(co, syq);
		ltx = longint'(px) * 20;
		lty = longint'(py) * 20;
		if (start) begin
			n = '{la, lb, lc, ld, ltx, lty};
		end else begin
			n.a = clamp(dot_q16(acc.a, la, acc.c, lb), 32);
			n.b = clamp(dot_q16(acc.b, la, acc.d, lb), 32);
			n.c = clamp(dot_q16(acc.a, lc, acc.c, ld), 32);
			n.d = clamp(dot_q16(acc.b, lc, acc.d, ld), 32);
			n.tx = clamp(dot_q16(acc.a, ltx, acc.c, lty) + acc.tx, 48);
			n.ty = clamp(dot_q16(acc.b, ltx, acc.d, lty) + acc.ty, 48);
		end
		acc = n;
		if (fin) world_q.push_back(n);
	endtask

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		error_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (world_q.size() == 0) begin
				report("unexpected result", 0, 0);
			end else begin
				xform_t w;
				w = world_q.pop_front();
				if (longint'($signed(m_tdata[31:0])) != w.a)
					report("mat_a", longint'($signed(m_tdata[31:0])), w.a);
				if (longint'($signed(m_tdata[63:32])) != w.b)
					report("mat_b", longint'($signed(m_tdata[63:32])), w.b);
				if (longint'($signed(m_tdata[95:64])) != w.c)
					report("mat_c", longint'($signed(m_tdata[95:64])), w.c);
				if (longint'($signed(m_tdata[127:96])) != w.d)
					report("mat_d", longint'($signed(m_tdata[127:96])), w.d);
				if (longint'($signed(m_tdata[175:128])) != w.tx)
					report("trans_x", longint'($signed(m_tdata[175:128])), w.tx);
				if (longint'($signed(m_tdata[223:176])) != w.ty)
					report("trans_y", longint'($signed(m_tdata[223:176])), w.ty);
			end
		end
	end

	// one node request, left valid after acceptance until the next call
	task automatic send_node(input logic signed [31:0] px, input logic signed [31:0] py,
			input logic signed [16:0] rot, input logic signed [23:0] sx,
			input logic signed [23:0] sy, input logic start, input logic fin);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tdata = {7'd0, sy, sx, rot, py, px};
		s_tuser = start;
		s_tlast = fin;
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		compose_node(px, py, rot, sx, sy, start, fin);
	endtask

	task automatic drain;
		@(negedge clk);
		s_tvalid = 1'b0;
		while (world_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed;
		// chain without a start right after reset composes onto zero
		send_node(32'sd160, -32'sd160, 17'sd0, 24'sd25600, 24'sd25600, 1'b0, 1'b1);
		send_node(32'sd16, 32'sd32, 17'sd5760, 24'sd25600, 24'sd25600, 1'b1, 1'b1);
		send_node(32'sh7fffffff, 32'sh80000000, 17'sd46079, 24'sh7fffff, 24'sh800000,
			1'b1, 1'b1);
		send_node(32'sh80000000, 32'sh7fffffff, -17'sd46080, 24'sh800000, 24'sh7fffff,
			1'b1, 1'b1);
		// rotation outside a full turn
		send_node(32'sd0, 32'sd0, 17'sd65535, 24'sd25600, -24'sd25600, 1'b1, 1'b1);
		send_node(32'sd0, 32'sd0, -17'sd65536, -24'sd25600, 24'sd12800, 1'b1, 1'b1);
		// fold boundaries and half turn
		send_node(32'sd100, 32'sd100, 17'sd11520, 24'sd25600, 24'sd25600, 1'b1, 1'b0);
		send_node(32'sd100, 32'sd100, -17'sd11520, 24'sd25600, 24'sd25600, 1'b0, 1'b0);
		send_node(32'sd100, 32'sd100, 17'sd23040, 24'sd25600, 24'sd25600, 1'b0, 1'b0);
		send_node(32'sd100, 32'sd100, -17'sd23040, 24'sd51200, 24'sd1, 1'b0, 1'b1);
		// zero and tiny scales
		send_node(32'sd5, -32'sd5, 17'sd1, 24'sd0, 24'sd0, 1'b1, 1'b0);
		send_node(32'sd5, -32'sd5, -17'sd1, -24'sd1, 24'sd1, 1'b0, 1'b1);
		// saturation through a long chain of large scales
		send_node(32'sh7fffffff, 32'sh7fffffff, 17'sd0, 24'sh7fffff, 24'sh7fffff, 1'b1, 1'b0);
		for (int i = 0; i < 3; i++)
			send_node(32'sh7fffffff, 32'sh80000000, 17'sd300, 24'sh7fffff, 24'sh7fffff,
				1'b0, i == 2);
		drain();
	endtask

	task automatic test_chains(input int idle, input int stall, input int n_items,
			input bit pause_mid);
		int sent, len;
		logic signed [31:0] px, py;
		logic signed [16:0] rot;
		logic signed [23:0] sx, sy;
		idle_pct = idle;
		stall_pct = stall;
		sent = 0;
		while (sent < n_items) begin
			if (pause_mid && sent >= n_items / 2 && sent < n_items / 2 + 8) begin
				drain();
				pause_mid = 0;
			end
			len = $urandom_range(1, 6);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(3) == 0) begin
					px = $urandom;
					py = $urandom;
					rot = 17'($urandom);
					sx = 24'($urandom);
					sy = 24'($urandom);
				end else begin
					px = $signed($urandom_range(0, 32000)) - 16000;
					py = $signed($urandom_range(0, 32000)) - 16000;
					rot = 17'($signed($urandom_range(0, 92159)) - 46080);
					sx = 24'($signed($urandom_range(0, 51200)) - 12800);
					sy = 24'($signed($urandom_range(0, 51200)) - 12800);
				end
				if ($urandom_range(9) == 0)
					// broken framing
					send_node(px, py, rot, sx, sy, 1'($urandom), 1'($urandom));
				else
					send_node(px, py, rot, sx, sy, k == 0, k == len - 1);
				sent++;
			end
		end
		drain();
	endtask

	initial begin
		arctan_q23 = '{377487360, 222843801, 117744544, 59768969, 30000467, 15014858,
			7509261, 3754860, 1877459, 938733, 469367, 234683,
			117342, 58671, 29335, 14668, 7334, 3667,
			1833, 917, 458, 229, 115, 57};
		acc = '{0, 0, 0, 0, 0, 0};
		error_count = 0;
		idle_pct = 0;
		stall_pct = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_chains(0, 0, 150, 0);
		test_chains(56, 0, 150, 1);
		test_chains(0, 56, 150, 0);
		test_chains(13, 13, 150, 0);

		repeat (100) @(posedge clk);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// watchdog
	initial begin
		#5ms;
		$display("== FAIL ==");
		$finish;
	end

endmodule
